// ===== rtl/swds_pkg.sv =====
`timescale 1ns / 1ps

package swds_pkg;

	localparam int DEPTH       = 8;
	localparam int SAMPLE_W    = 16;
	localparam int COUNT_OUT_W = 4;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int SUM_W       = SAMPLE_W + $clog2(DEPTH);
	localparam int SUM_DIV_W   = SUM_W + (SUM_W % 2);
	localparam int DEV_W       = 16;
	localparam int SQ_W        = 2 * DEV_W + $clog2(DEPTH);
	localparam int DIV_W       = SQ_W + (SQ_W % 2);
	localparam int REM_W       = CNT_W + 1;
	localparam int ROOT_W      = DEV_W;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int SQREM_W     = ROOT_W + 3;

	// divider retires two quotient bits per step, root one bit per step
	localparam int MEAN_DIV_STEPS = SUM_DIV_W / 2;
	localparam int VAR_DIV_STEPS  = DIV_W / 2;
	localparam int ROOT_STEPS     = ROOT_W;
	localparam int LOOP_W         = $clog2(VAR_DIV_STEPS);
	localparam int PC_W           = 4;

	localparam logic OPC_WRITE = 1'b0;
	localparam logic OPC_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_SUM,
		DP_LOAD_MEAN,
		DP_DIV,
		DP_SET_MEAN,
		DP_DEV,
		DP_LOAD_VAR,
		DP_LOAD_ROOT,
		DP_ROOT,
		DP_OUT
	} dp_op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_IN,
		COND_EMPTY,
		COND_MORE,
		COND_LOOP,
		COND_OUT
	} cond_t;

	typedef struct packed {
		dp_op_t            op;
		cond_t             cond;
		logic [PC_W-1:0]   target;
		logic              load_cnt;
		logic [LOOP_W-1:0] cnt;
		logic              in_ready;
	} ctrl_word_t;

	typedef struct packed {
		logic empty;
		logic idx_last;
		logic out_busy;
	} dp_status_t;

	localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
	localparam logic [PC_W-1:0] PC_CLEAR  = PC_W'(1);
	localparam logic [PC_W-1:0] PC_SUM    = PC_W'(2);
	localparam logic [PC_W-1:0] PC_LOADM  = PC_W'(3);
	localparam logic [PC_W-1:0] PC_DIVM   = PC_W'(4);
	localparam logic [PC_W-1:0] PC_SETM   = PC_W'(5);
	localparam logic [PC_W-1:0] PC_DEV    = PC_W'(6);
	localparam logic [PC_W-1:0] PC_DRAIN0 = PC_W'(7);
	localparam logic [PC_W-1:0] PC_DRAIN1 = PC_W'(8);
	localparam logic [PC_W-1:0] PC_LOADV  = PC_W'(9);
	localparam logic [PC_W-1:0] PC_DIVV   = PC_W'(10);
	localparam logic [PC_W-1:0] PC_LOADR  = PC_W'(11);
	localparam logic [PC_W-1:0] PC_ROOT   = PC_W'(12);
	localparam logic [PC_W-1:0] PC_DONE   = PC_W'(13);

	// microcode ROM
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w.op       = DP_NOP;
		w.cond     = COND_NEXT;
		w.target   = PC_IDLE;
		w.load_cnt = 1'b0;
		w.cnt      = '0;
		w.in_ready = 1'b0;
		case (pc)
			PC_IDLE: begin
				w.cond     = COND_IN;
				w.target   = PC_CLEAR;
				w.in_ready = 1'b1;
			end
			PC_CLEAR: begin
				w.op     = DP_CLEAR;
				w.cond   = COND_EMPTY;
				w.target = PC_DONE;
			end
			PC_SUM: begin
				w.op     = DP_SUM;
				w.cond   = COND_MORE;
				w.target = PC_SUM;
			end
			PC_LOADM: begin
				w.op       = DP_LOAD_MEAN;
				w.load_cnt = 1'b1;
				w.cnt      = LOOP_W'(MEAN_DIV_STEPS - 1);
			end
			PC_DIVM: begin
				w.op     = DP_DIV;
				w.cond   = COND_LOOP;
				w.target = PC_DIVM;
			end
			PC_SETM: begin
				w.op = DP_SET_MEAN;
			end
			PC_DEV: begin
				w.op     = DP_DEV;
				w.cond   = COND_MORE;
				w.target = PC_DEV;
			end
			PC_DRAIN0: begin
				w.op = DP_NOP;
			end
			PC_DRAIN1: begin
				w.op = DP_NOP;
			end
			PC_LOADV: begin
				w.op       = DP_LOAD_VAR;
				w.load_cnt = 1'b1;
				w.cnt      = LOOP_W'(VAR_DIV_STEPS - 1);
			end
			PC_DIVV: begin
				w.op     = DP_DIV;
				w.cond   = COND_LOOP;
				w.target = PC_DIVV;
			end
			PC_LOADR: begin
				w.op       = DP_LOAD_ROOT;
				w.load_cnt = 1'b1;
				w.cnt      = LOOP_W'(ROOT_STEPS - 1);
			end
			PC_ROOT: begin
				w.op     = DP_ROOT;
				w.cond   = COND_LOOP;
				w.target = PC_ROOT;
			end
			PC_DONE: begin
				w.op     = DP_OUT;
				w.cond   = COND_OUT;
				w.target = PC_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/swds_seq.sv =====
`timescale 1ns / 1ps

module swds_seq
	import swds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	input  dp_status_t status,
	output ctrl_word_t ctrl,
	output logic       take
);

	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   pc_d;
	logic [PC_W-1:0]   pc_inc;
	logic [LOOP_W-1:0] cnt_q;
	logic [LOOP_W-1:0] cnt_d;

	assign ctrl   = ucode(pc_q);
	assign take   = sample_valid && ctrl.in_ready;
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		case (ctrl.cond)
			COND_NEXT:   pc_d = pc_inc;
			COND_ALWAYS: pc_d = ctrl.target;
			COND_IN:     pc_d = take ? ctrl.target : pc_q;
			COND_EMPTY:  pc_d = status.empty ? ctrl.target : pc_inc;
			COND_MORE:   pc_d = status.idx_last ? pc_inc : ctrl.target;
			COND_LOOP:   pc_d = (cnt_q != '0) ? ctrl.target : pc_inc;
			COND_OUT:    pc_d = status.out_busy ? pc_q : ctrl.target;
			default:     pc_d = PC_IDLE;
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ctrl.load_cnt) begin
			cnt_d = ctrl.cnt;
		end else if (ctrl.cond == COND_LOOP && cnt_q != '0) begin
			cnt_d = cnt_q - LOOP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_IDLE;
			cnt_q <= '0;
		end else begin
			pc_q  <= pc_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== rtl/swds_dp.sv =====
`timescale 1ns / 1ps

module swds_dp
	import swds_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_word_t                 ctrl,
	input  logic                       take,
	input  logic                       opcode,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       result_stall,
	output dp_status_t                 status,
	output logic                       result_valid,
	output logic [COUNT_OUT_W-1:0]     filled_count,
	output logic signed [SAMPLE_W-1:0] window_mean,
	output logic [DEV_W-1:0]           max_deviation,
	output logic [ROOT_W-1:0]          std_deviation
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic signed [SAMPLE_W-1:0] rd_q;

	logic [IDX_W-1:0]  slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_nx;

	logic signed [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]           sum_mag;
	logic                       neg_q;
	logic [SUM_DIV_W-1:0]       mean_quot;
	logic signed [SAMPLE_W-1:0] mean_q;

	logic signed [DEV_W:0] dev;
	logic [DEV_W:0]        dev_abs;
	logic [DEV_W-1:0]      a_s1;
	logic                  a_vld_s1;
	logic [2*DEV_W-1:0]    sq_s2;
	logic                  sq_vld_s2;
	logic [SQ_W-1:0]       acc_q;
	logic [DEV_W-1:0]      maxdev_q;

	logic [DIV_W-1:0] div_q;
	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] div_nx;
	logic [REM_W-1:0] rem_nx;

	logic [RAD_W-1:0]   rad_q;
	logic [SQREM_W-1:0] sqrem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [SQREM_W-1:0] sq_t;
	logic [SQREM_W-1:0] sq_trial;

	logic                   out_valid_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	logic [SAMPLE_W-1:0]    out_mean_q;
	logic [DEV_W-1:0]       out_maxdev_q;
	logic [ROOT_W-1:0]      out_root_q;
	logic                   out_busy;

	assign out_busy        = out_valid_q && result_stall;
	assign status.empty    = (count_q == '0);
	assign status.idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign status.out_busy = out_busy;

	// ring write on transfer; read is registered one address ahead of the loop
	always_comb begin
		case (ctrl.op)
			DP_CLEAR, DP_SET_MEAN: idx_nx = '0;
			DP_SUM, DP_DEV:        idx_nx = idx_q + IDX_W'(1);
			default:               idx_nx = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && opcode == OPC_WRITE) begin
			mem[slot_q] <= sample;
		end
		rd_q <= mem[idx_nx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			if (opcode == OPC_CLEAR) begin
				slot_q  <= '0;
				count_q <= '0;
			end else begin
				slot_q <= (slot_q == IDX_W'(DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
				if (count_q != CNT_W'(DEPTH)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// two restoring division steps per cycle, divisor is the fill count
	always_comb begin
		logic [REM_W-1:0] r;
		logic [DIV_W-1:0] q;
		r = rem_q;
		q = div_q;
		for (int k = 0; k < 2; k++) begin
			r = {r[REM_W-2:0], q[DIV_W-1]};
			q = {q[DIV_W-2:0], 1'b0};
			if (r >= REM_W'(count_q)) begin
				r    = r - REM_W'(count_q);
				q[0] = 1'b1;
			end
		end
		rem_nx = r;
		div_nx = q;
	end

	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign mean_quot = div_q[SUM_DIV_W-1:0];

	assign dev     = (DEV_W+1)'(rd_q) - (DEV_W+1)'(mean_q);
	assign dev_abs = dev[DEV_W] ? (DEV_W+1)'(-dev) : (DEV_W+1)'(dev);

	// one root bit per step
	assign sq_t     = {sqrem_q[SQREM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign sq_trial = SQREM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s1  <= 1'b0;
			sq_vld_s2 <= 1'b0;
		end else begin
			a_vld_s1  <= (ctrl.op == DP_DEV);
			sq_vld_s2 <= a_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_nx;
		a_s1  <= dev_abs[DEV_W-1:0];
		sq_s2 <= a_s1 * a_s1;
		if (sq_vld_s2) begin
			acc_q <= acc_q + SQ_W'(sq_s2);
		end
		case (ctrl.op)
			DP_CLEAR: begin
				sum_q    <= '0;
				acc_q    <= '0;
				mean_q   <= '0;
				maxdev_q <= '0;
				root_q   <= '0;
			end
			DP_SUM: begin
				sum_q <= sum_q + SUM_W'(rd_q);
			end
			DP_LOAD_MEAN: begin
				neg_q <= sum_q[SUM_W-1];
				rem_q <= '0;
				div_q <= DIV_W'(sum_mag) << (DIV_W - SUM_DIV_W);
			end
			DP_DIV: begin
				rem_q <= rem_nx;
				div_q <= div_nx;
			end
			DP_SET_MEAN: begin
				mean_q <= SAMPLE_W'(neg_q ? (SUM_DIV_W'(0) - mean_quot) : mean_quot);
			end
			DP_DEV: begin
				if (dev_abs[DEV_W-1:0] > maxdev_q) begin
					maxdev_q <= dev_abs[DEV_W-1:0];
				end
			end
			DP_LOAD_VAR: begin
				rem_q <= '0;
				div_q <= DIV_W'(acc_q);
			end
			DP_LOAD_ROOT: begin
				rad_q   <= div_q[RAD_W-1:0];
				sqrem_q <= '0;
				root_q  <= '0;
			end
			DP_ROOT: begin
				rad_q <= rad_q << 2;
				if (sq_t >= sq_trial) begin
					sqrem_q <= sq_t - sq_trial;
					root_q  <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					sqrem_q <= sq_t;
					root_q  <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// result register: holds one finished result while the next item runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == DP_OUT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == DP_OUT && !out_busy) begin
			out_count_q  <= COUNT_OUT_W'(count_q);
			out_mean_q   <= mean_q;
			out_maxdev_q <= maxdev_q;
			out_root_q   <= root_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign filled_count  = out_count_q;
	assign window_mean   = out_mean_q;
	assign max_deviation = out_maxdev_q;
	assign std_deviation = out_root_q;

endmodule

// ===== rtl/sliding_window_deviation_stats.sv =====
`timescale 1ns / 1ps

// Keeps the last eight signed samples and reports, after every item (write
// or clear), the fill count, the mean truncated toward zero, the largest
// absolute deviation from that mean and the floor square root of the mean
// squared deviation; an empty window reports zeros. A microcoded sequencer
// steps one shared datapath: a pass over the filled entries for the sum, a
// radix-4 divide by the count, a second pass for deviations and squares,
// another divide and a bit-per-step square root. Each item waits on the two
// walks of the sample ring and the divide and root loops; after a clear the
// window is empty and the sequencer goes straight to the output.
// One finished result can wait in the output register while the next item
// is already being worked on.

module sliding_window_deviation_stats
	import swds_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic                       opcode,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [COUNT_OUT_W-1:0]     filled_count,
	output logic signed [SAMPLE_W-1:0] window_mean,
	output logic [DEV_W-1:0]           max_deviation,
	output logic [ROOT_W-1:0]          std_deviation
);

	ctrl_word_t ctrl;
	dp_status_t status;
	logic       take;

	assign sample_stall = !ctrl.in_ready;

	swds_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.status       (status),
		.ctrl         (ctrl),
		.take         (take)
	);

	swds_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.take          (take),
		.opcode        (opcode),
		.sample        (sample),
		.result_stall  (result_stall),
		.status        (status),
		.result_valid  (result_valid),
		.filled_count  (filled_count),
		.window_mean   (window_mean),
		.max_deviation (max_deviation),
		.std_deviation (std_deviation)
	);

endmodule

// ===== rtl/swds_chk.sv =====
`timescale 1ns / 1ps

module swds_chk
	import swds_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       sample_valid,
	input logic                       sample_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [COUNT_OUT_W-1:0]     filled_count,
	input logic signed [SAMPLE_W-1:0] window_mean,
	input logic [DEV_W-1:0]           max_deviation,
	input logic [ROOT_W-1:0]          std_deviation
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(window_mean) && $stable(std_deviation)
			&& $stable(max_deviation) && $stable(filled_count))
		else $error("stalled result changed");

	// every transfer starts work, so the block cannot take the next one at once
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("input taken on consecutive cycles");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && filled_count == '0 |->
			window_mean == '0 && max_deviation == '0 && std_deviation == '0)
		else $error("empty window reports nonzero stats");

	a_sd_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> std_deviation <= max_deviation)
		else $error("std deviation above max deviation");

endmodule

bind sliding_window_deviation_stats swds_chk u_swds_chk (.*);
